>>> design/dstb_pkg.sv
// Package of shared types and constants for the depth sorted triangle buffer.
package dstb_pkg;
  localparam int DefCapacity = 64;
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] depth_key;
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] bx;
    logic signed [23:0] by_coord;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [15:0] attr_tag;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic accepted;
    logic signed [19:0] px_a;
    logic signed [19:0] py_a;
    logic signed [19:0] px_b;
    logic signed [19:0] py_b;
    logic signed [19:0] px_c;
    logic signed [19:0] py_c;
    logic [15:0] tag_out;
    logic last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;      // write the input triangle at the fill count
    logic clear;      // empty the buffer
    logic scan_start; // restart the minimum search
    logic scan_step;  // examine the entry at the scan pointer
    logic pick;       // mark the found minimum as taken and read it out
    logic emit_push;  // load a push reply into the output register
    logic emit_tri;   // load a scaled triangle into the output register
    logic out_take;   // output register was taken
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;  // scan pointer has passed the last entry
    logic remain_one; // only one entry left to emit
    logic out_busy;   // output register holds an item
    logic scale_done; // scaled triangle is ready
  } stat_t;
endpackage

>>> design/dstb_if.sv
// Valid/ready channel interfaces for the depth sorted triangle buffer.
interface dstb_in_if import dstb_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dstb_out_if import dstb_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dstb_cfg_if ();
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [11:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> design/dstb_datapath.sv
// Datapath: triangle store, minimum depth search, pixel scaling and output register.
module dstb_datapath import dstb_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output stat_t stat,
  input  in_item_t in_data,
  input  logic push_ok,
  input  logic [11:0] canvas_width,
  input  logic [11:0] canvas_height,
  output out_item_t out_data
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [23:0]  depth_mem [CAPACITY];
  logic [143:0] vert_mem  [CAPACITY];
  logic [15:0]  tag_mem   [CAPACITY];
  logic [CAPACITY-1:0] taken;
  logic [CW-1:0] count;
  logic [CW-1:0] remain;
  logic [CW-1:0] scan;
  logic [23:0] best_key;
  logic [IW-1:0] best_idx;
  logic best_valid;
  logic [23:0] scan_key;
  logic scan_taken;
  logic scan_live;
  logic [143:0] rd_vert;
  logic [15:0] rd_tag;
  logic rd_last;
  logic [2:0] sstage;
  logic [2:0] vsel;
  logic signed [36:0] prod;
  logic signed [23:0] coord;
  logic [11:0] size;
  logic signed [19:0] pix [6];
  logic out_busy;

  // Insertion of the incoming triangle.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      depth_mem[count[IW-1:0]] <= in_data.depth_key;
      vert_mem[count[IW-1:0]] <= {in_data.ax, in_data.ay, in_data.bx, in_data.by_coord,
                                  in_data.cx, in_data.cy};
      tag_mem[count[IW-1:0]] <= in_data.attr_tag;
    end
  end

  // Registered read at the scan pointer and at the picked entry.
  always_ff @(posedge clk) begin
    scan_key <= depth_mem[scan[IW-1:0]];
    if (cmd.pick) begin
      rd_vert <= vert_mem[best_idx];
      rd_tag <= tag_mem[best_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      taken <= '0;
    end else begin
      if (cmd.store) count <= count + CW'(1);
      if (cmd.pick) taken[best_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (cmd.clear) begin
      remain <= '0;
    end else if (cmd.store) begin
      remain <= remain + CW'(1);
    end else if (cmd.pick) begin
      remain <= remain - CW'(1);
    end
  end

  // Minimum search, one entry per cycle; the first minimum wins, keeping
  // insertion order among equal keys.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
      scan_live <= 1'b0;
      best_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      scan <= '0;
      scan_live <= 1'b0;
      best_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan != count) scan <= scan + CW'(1);
      scan_live <= (scan != count);
      scan_taken <= taken[scan[IW-1:0]];
      best_key <= best_key;
      if (scan_live && !scan_taken && (!best_valid || scan_key < best_key)) begin
        best_valid <= 1'b1;
        best_key <= scan_key;
        best_idx <= IW'(scan - CW'(1));
      end
    end
  end

  // Pixel scaling: one 24x12 multiply per cycle over the six coordinates.
  always_comb begin
    vsel = 3'd5 - sstage;
    coord = rd_vert[vsel*24 +: 24];
    size = sstage[0] ? canvas_height : canvas_width;
    prod = coord * $signed({1'b0, size});
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.pick) begin
      sstage <= '0;
    end else if (sstage != 3'd6) begin
      sstage <= sstage + 3'd1;
    end
    if (sstage != 3'd6) begin
      // Truncate toward zero: bias negative products before the shift.
      pix[sstage] <= 20'((prod + (prod[36] ? 37'sd65535 : 37'sd0)) >>> 16);
    end
    if (cmd.pick) rd_last <= (remain == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
    end else if (cmd.emit_push || cmd.emit_tri) begin
      out_busy <= 1'b1;
    end else if (cmd.out_take) begin
      out_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_push) begin
      out_data <= '0;
      out_data.accepted <= push_ok;
    end else if (cmd.emit_tri) begin
      out_data.kind <= 1'b1;
      out_data.accepted <= 1'b0;
      out_data.px_a <= pix[0];
      out_data.py_a <= pix[1];
      out_data.px_b <= pix[2];
      out_data.py_b <= pix[3];
      out_data.px_c <= pix[4];
      out_data.py_c <= pix[5];
      out_data.tag_out <= rd_tag;
      out_data.last <= rd_last;
    end
  end

  assign stat.full = (count == CW'(CAPACITY));
  assign stat.empty = (remain == '0);
  assign stat.scan_done = !scan_live && (scan == count) && cmd.scan_step == 1'b0 ? 1'b0
                          : (!scan_live && scan == count);
  assign stat.remain_one = (remain == CW'(1));
  assign stat.out_busy = out_busy;
  assign stat.scale_done = (sstage == 3'd6);

  assert property (@(posedge clk) disable iff (rst) cmd.store |-> !stat.full)
    else $error("store into a full buffer");
  assert property (@(posedge clk) disable iff (rst) remain <= count)
    else $error("remaining entries exceed fill count");
  assert property (@(posedge clk) disable iff (rst) cmd.pick |-> best_valid)
    else $error("pick without a found minimum");
endmodule

>>> design/dstb_ctrl.sv
// Controller state machine for the depth sorted triangle buffer.
module dstb_ctrl import dstb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [1:0] in_cmd,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  input  stat_t stat,
  output cmd_t cmd,
  output logic push_ok
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic accept;
  logic was_last;

  assign out_valid = stat.out_busy;
  assign in_ready = (state == S_IDLE) && (!stat.out_busy || out_ready);
  assign accept = in_valid && in_ready;
  assign push_ok = !stat.full;

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.out_take = out_valid && out_ready;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_PUSH: begin
              cmd.store = !stat.full;
              cmd.emit_push = 1'b1;
            end
            CMD_DRAW: begin
              if (!stat.empty) begin
                cmd.scan_start = 1'b1;
                state_next = S_SCAN;
              end
            end
            CMD_FLUSH: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        if (stat.scale_done && (!stat.out_busy || out_ready)) begin
          cmd.emit_tri = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (was_last) begin
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      was_last <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.pick) was_last <= stat.remain_one;
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept |-> state == S_IDLE)
    else $error("input accepted during a draw");
  assert property (@(posedge clk) disable iff (rst) cmd.emit_tri |-> !stat.out_busy || out_ready)
    else $error("output register overwritten");
  assert property (@(posedge clk) disable iff (rst) state == S_PICK |=> state == S_SCALE)
    else $error("pick not followed by scaling");
endmodule

>>> design/depth_sorted_triangle_buffer.sv
// Top level of the depth sorted triangle buffer.
// A push is answered by a reply loaded into the output register; a flush gives no reply.
// A draw emits N triangles; each needs a minimum search over the store, one entry per
// cycle, followed by selection and scaling.
// The store itself is not cleared: reset zeroes the fill count, taken flags and counters,
// returns the controller to idle and the canvas size registers to 320 by 240.
module depth_sorted_triangle_buffer import dstb_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input logic clk,
  input logic rst,
  dstb_in_if.sink in_ch,
  dstb_out_if.source out_ch,
  dstb_cfg_if.sink cfg
);
  cmd_t cmd;
  stat_t stat;
  logic push_ok;
  logic [11:0] canvas_width;
  logic [11:0] canvas_height;

  // Configuration registers accept a write in any cycle.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width <= 12'd320;
      canvas_height <= 12'd240;
    end else if (cfg.valid) begin
      if (cfg.index == REG_WIDTH) canvas_width <= cfg.wdata;
      if (cfg.index == REG_HEIGHT) canvas_height <= cfg.wdata;
    end
  end

  // The controller sequences each transaction; the datapath holds the store.
  dstb_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_cmd(in_ch.data.cmd), .in_ready(in_ch.ready),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .stat, .cmd, .push_ok
  );

  dstb_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .cmd, .stat, .in_data(in_ch.data), .push_ok,
    .canvas_width, .canvas_height, .out_data(out_ch.data)
  );
endmodule

>>> dv/depth_sorted_triangle_buffer_tb.sv
// Self-checking testbench for the depth sorted triangle buffer: directed and random traffic.
module depth_sorted_triangle_buffer_tb;
  import dstb_pkg::*;

  // Command code 3 has no meaning; the block must drop it without a reply.
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int Capacity = DefCapacity;
  // Each triangle of a draw needs a search over the whole store; an idle gap that
  // reaches this limit can only mean a hang.
  localparam int WatchdogLimit = 6000;
  // Settling time after the last expected result, covering flushes and dropped
  // commands that produce nothing to wait for.
  localparam int SettleCycles = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dstb_in_if  in_ch ();
  dstb_out_if out_ch ();
  dstb_cfg_if cfg ();

  depth_sorted_triangle_buffer uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's state, updated at each accepted transaction.
  in_item_t    stored_tris[Capacity];
  int          stored_count;
  logic [11:0] canvas_w;
  logic [11:0] canvas_h;

  // Results the block still owes us, oldest first.
  out_item_t pending_results[$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_WIDTH;
    cfg.wdata    = '0;
  end

  // Scale a normalized Q7.16 coordinate to pixels; SystemVerilog integer
  // division truncates toward zero, which is what the block must do.
  function automatic logic signed [19:0] to_pixel(input logic signed [23:0] coord,
                                                  input logic [11:0] size);
    longint prod;
    prod = longint'(coord) * longint'({1'b0, size});
    prod = prod / 65536;
    return prod[19:0];
  endfunction

  // Predict what one accepted input transaction produces and update the shadow state.
  task automatic predict_buffer(input in_item_t it);
    out_item_t res;
    int order[Capacity];
    int key;
    int j;
    case (it.cmd)
      CMD_PUSH: begin
        res = '0;
        if (stored_count < Capacity) begin
          stored_tris[stored_count] = it;
          stored_count++;
          res.accepted = 1'b1;
        end
        pending_results.push_back(res);
      end
      CMD_DRAW: begin
        // Stable insertion sort by depth keeps equal keys in push order.
        for (int i = 0; i < stored_count; i++) begin
          key = i;
          j = i;
          while (j > 0 && stored_tris[order[j-1]].depth_key > stored_tris[key].depth_key) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = key;
        end
        for (int i = 0; i < stored_count; i++) begin
          res = '0;
          res.kind    = 1'b1;
          res.px_a    = to_pixel(stored_tris[order[i]].ax, canvas_w);
          res.py_a    = to_pixel(stored_tris[order[i]].ay, canvas_h);
          res.px_b    = to_pixel(stored_tris[order[i]].bx, canvas_w);
          res.py_b    = to_pixel(stored_tris[order[i]].by_coord, canvas_h);
          res.px_c    = to_pixel(stored_tris[order[i]].cx, canvas_w);
          res.py_c    = to_pixel(stored_tris[order[i]].cy, canvas_h);
          res.tag_out = stored_tris[order[i]].attr_tag;
          res.last    = (i == stored_count - 1);
          pending_results.push_back(res);
        end
        stored_count = 0;
      end
      CMD_FLUSH: stored_count = 0;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Result checker: every transaction on the output channel must match the
  // oldest outstanding prediction.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: kind %0d tag %0d", got.kind, got.tag_out);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("accepted", want.accepted, got.accepted);
        check_field("px_a", want.px_a, got.px_a);
        check_field("py_a", want.py_a, got.py_a);
        check_field("px_b", want.px_b, got.px_b);
        check_field("py_b", want.py_b, got.py_b);
        check_field("px_c", want.px_c, got.px_c);
        check_field("py_c", want.py_c, got.py_c);
        check_field("tag_out", want.tag_out, got.tag_out);
        check_field("last", want.last, got.last);
      end
    end
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The watchdog restarts whenever any channel completes a transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL depth_sorted_triangle_buffer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one input transaction, with an optional random gap in front of it.
  // Valid stays high between back-to-back items so it never drops and rises in one step.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_buffer(it);
  endtask

  // Stop sending, then wait until all predicted results have been seen and the
  // block has had time to finish any silent command.
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Valid drops for one cycle after each write, so back-to-back writes never
  // assign it twice in one step.
  task automatic write_canvas(input logic index, input logic [11:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.wdata <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (index == REG_WIDTH) canvas_w = value;
    else canvas_h = value;
    @(posedge clk);
  endtask

  // A triangle with fully random payload; a narrow depth range forces ties.
  function automatic in_item_t random_tri(input logic [1:0] cmd);
    in_item_t it;
    it.cmd       = cmd;
    it.depth_key = ($urandom_range(3) == 0) ? 24'($urandom_range(7)) : 24'($urandom);
    it.ax        = 24'($urandom);
    it.ay        = 24'($urandom);
    it.bx        = 24'($urandom);
    it.by_coord  = 24'($urandom);
    it.cx        = 24'($urandom);
    it.cy        = 24'($urandom);
    it.attr_tag  = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_tri(input logic [23:0] depth,
                                        input logic signed [23:0] x,
                                        input logic signed [23:0] y,
                                        input logic [15:0] tag);
    in_item_t it;
    it = '0;
    it.cmd       = CMD_PUSH;
    it.depth_key = depth;
    it.ax        = x;
    it.ay        = y;
    it.bx        = -x;
    it.by_coord  = -y;
    it.cx        = y;
    it.cy        = x;
    it.attr_tag  = tag;
    return it;
  endfunction

  // Default canvas after reset, extreme coordinates and ties in depth.
  task automatic test_reset_canvas();
    send_item(make_tri(24'd5, 24'sh7fffff, -24'sd8388608, 16'hffff));
    send_item(make_tri(24'd2, 24'sd65536, -24'sd1, 16'h0000));
    send_item(make_tri(24'd5, -24'sd65535, 24'sd0, 16'h1234));
    send_item(make_tri(24'hffffff, 24'sd1, 24'sd32768, 16'h8000));
    send_item(make_tri(24'd0, -24'sd32768, 24'sh400000, 16'h0001));
    send_item(random_tri(CMD_DRAW));
    drain_outputs();
  endtask

  // Draw of an empty buffer, the unused command code, and a flush that discards work.
  task automatic test_empty_and_flush();
    send_item(random_tri(CMD_DRAW));
    send_item(random_tri(CmdUnused));
    send_item(random_tri(CMD_PUSH));
    send_item(random_tri(CMD_PUSH));
    send_item(random_tri(CMD_FLUSH));
    send_item(random_tri(CMD_DRAW));
    send_item(random_tri(CMD_PUSH));
    send_item(random_tri(CMD_DRAW));
    drain_outputs();
  endtask

  // Canvas sizes at the ends of their range, including a zero size.
  task automatic test_canvas_extremes();
    write_canvas(REG_WIDTH, 12'd4095);
    write_canvas(REG_HEIGHT, 12'd1);
    send_item(make_tri(24'd9, 24'sh7fffff, -24'sd8388608, 16'h00ff));
    send_item(make_tri(24'd3, -24'sd8388608, 24'sh7fffff, 16'hff00));
    send_item(random_tri(CMD_DRAW));
    drain_outputs();
    write_canvas(REG_WIDTH, 12'd0);
    write_canvas(REG_HEIGHT, 12'd4095);
    send_item(make_tri(24'd1, -24'sd8388608, -24'sd8388608, 16'h5a5a));
    send_item(random_tri(CMD_DRAW));
    drain_outputs();
  endtask

  // Random traffic built from push bursts closed by a draw, with some flushes,
  // dropped commands and occasional bursts that overfill the buffer.
  task automatic test_random_phase(input int n_items);
    int sent;
    int burst;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(99) < 8) ? Capacity + 2 : $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) send_item(random_tri(CMD_PUSH));
      sent += burst;
      pick = $urandom_range(99);
      if (pick < 70) send_item(random_tri(CMD_DRAW));
      else if (pick < 85) send_item(random_tri(CMD_FLUSH));
      else if (pick < 93) send_item(random_tri(CmdUnused));
      else begin
        send_item(random_tri(CMD_DRAW));
        send_item(random_tri(CMD_DRAW));
      end
      sent++;
    end
    send_item(random_tri(CMD_DRAW));
    drain_outputs();
  endtask

  initial begin
    stored_count = 0;
    canvas_w = 12'd320;
    canvas_h = 12'd240;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 34;
    recv_idle_pct = 51;
    test_reset_canvas();
    test_empty_and_flush();
    test_canvas_extremes();

    write_canvas(REG_WIDTH, 12'($urandom_range(1, 4095)));
    write_canvas(REG_HEIGHT, 12'($urandom_range(1, 4095)));
    test_random_phase(90);

    send_idle_pct = 51;
    recv_idle_pct = 34;
    write_canvas(REG_WIDTH, 12'($urandom_range(1, 4095)));
    write_canvas(REG_HEIGHT, 12'($urandom_range(1, 4095)));
    test_random_phase(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_canvas(REG_WIDTH, 12'd320);
    write_canvas(REG_HEIGHT, 12'd240);
    test_random_phase(90);

    if (fail_count == 0) begin
      $display("PASS depth_sorted_triangle_buffer");
    end else begin
      $display("FAIL depth_sorted_triangle_buffer");
    end
    $finish;
  end

endmodule
